// ===== rtl/barycentric_point_in_triangle_unit_macros.svh =====
// Assertion macros for the barycentric point-in-triangle unit.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef BARYCENTRIC_POINT_IN_TRIANGLE_UNIT_MACROS_SVH
`define BARYCENTRIC_POINT_IN_TRIANGLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BPIT_ASSERT_IMPL(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPIT_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/bpit_pkg.sv =====
// Shared constants and pipeline word type for the barycentric triangle unit.
// No dependencies.
package bpit_pkg;

    localparam int COORD_BITS       = 24;
    localparam int LAMBDA_FRAC_BITS = 30;
    localparam int TOL_BITS         = 31;
    localparam int LAM_BITS         = 31;
    localparam int NUM_COORDS       = 12;
    localparam int IN_BITS          = NUM_COORDS * COORD_BITS;
    localparam int IN_BYTES_BITS    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS         = 2 + 3 * LAM_BITS;
    localparam int OUT_BYTES_BITS   = ((OUT_BITS + 7) / 8) * 8;

    // Internal widths.
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int DET_BITS  = PROD_BITS + 1;
    localparam int MAG_BITS  = PROD_BITS;
    localparam int HI_BITS   = MAG_BITS - 32;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int T2_BITS   = 2 * TOL_BITS;
    localparam int T2HI_BITS = T2_BITS - 32;
    localparam int CMP_BITS  = SQ_BITS + 64;
    localparam int REM_BITS  = MAG_BITS + 1;
    localparam int Q_BITS    = 35;
    localparam int Q_FRAC    = 30;
    localparam int NUM_SHIFT = Q_BITS - Q_FRAC;
    localparam int L_BITS    = Q_BITS + 4;
    localparam int LAM_SHIFT = Q_FRAC - LAMBDA_FRAC_BITS;

    // Pipeline stage numbers.
    localparam int ST_CAPTURE  = 0;
    localparam int ST_EXTENT   = 1;
    localparam int ST_PLANE    = 2;
    localparam int ST_MUL      = 3;
    localparam int ST_SUM      = 4;
    localparam int ST_ABS      = 5;
    localparam int ST_PART     = 6;
    localparam int ST_DIV0     = 7;
    localparam int DIV_STAGES  = (Q_BITS + 1) / 2;
    localparam int ST_SQSUM    = 7;
    localparam int ST_RPART    = 8;
    localparam int ST_RSUM     = 9;
    localparam int ST_DEGEN    = 10;
    localparam int ST_WEIGHT   = ST_DIV0 + DIV_STAGES;
    localparam int ST_OUT      = ST_WEIGHT + 1;
    localparam int NUM_STAGES  = ST_OUT + 1;

    // Configuration register indexes and reset values.
    localparam logic REG_DIM = 1'b0;
    localparam logic REG_TOL = 1'b1;
    localparam logic [1:0]          DIM_3D    = 2'd3;
    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

    typedef struct packed {
        logic [NUM_COORDS-1:0][COORD_BITS-1:0] crd;
        logic [2:0][DIFF_BITS-1:0]             ext;
        logic signed [DIFF_BITS-1:0]           u0;
        logic signed [DIFF_BITS-1:0]           u1;
        logic signed [DIFF_BITS-1:0]           v0;
        logic signed [DIFF_BITS-1:0]           v1;
        logic signed [DIFF_BITS-1:0]           w0;
        logic signed [DIFF_BITS-1:0]           w1;
        logic signed [PROD_BITS-1:0]           m_u0v1;
        logic signed [PROD_BITS-1:0]           m_u1v0;
        logic signed [PROD_BITS-1:0]           m_v1w0;
        logic signed [PROD_BITS-1:0]           m_v0w1;
        logic signed [PROD_BITS-1:0]           m_u0w1;
        logic signed [PROD_BITS-1:0]           m_u1w0;
        logic signed [PROD_BITS-1:0]           sq_u0;
        logic signed [PROD_BITS-1:0]           sq_u1;
        logic signed [PROD_BITS-1:0]           sq_v0;
        logic signed [PROD_BITS-1:0]           sq_v1;
        logic [T2_BITS-1:0]                    t2;
        logic signed [DET_BITS-1:0]            det;
        logic signed [DET_BITS-1:0]            n0;
        logic signed [DET_BITS-1:0]            n1;
        logic [MAG_BITS-1:0]                   na;
        logic [MAG_BITS-1:0]                   nb;
        logic [MAG_BITS-1:0]                   dm;
        logic [MAG_BITS-1:0]                   nm0;
        logic [MAG_BITS-1:0]                   nm1;
        logic                                  sgn0;
        logic                                  sgn1;
        logic [2*HI_BITS-1:0]                  dd_hh;
        logic [MAG_BITS-1:0]                   dd_hl;
        logic [63:0]                           dd_ll;
        logic [2*HI_BITS-1:0]                  nn_hh;
        logic [MAG_BITS-1:0]                   nn_hl;
        logic [MAG_BITS-1:0]                   nn_lh;
        logic [63:0]                           nn_ll;
        logic [SQ_BITS-1:0]                    det2;
        logic [SQ_BITS-1:0]                    nanb;
        logic [3:0][63:0]                      plo;
        logic [3:0][63:0]                      phi;
        logic [CMP_BITS-1:0]                   slo;
        logic [CMP_BITS-1:0]                   shi;
        logic                                  degen;
        logic [REM_BITS-1:0]                   r0;
        logic [REM_BITS-1:0]                   r1;
        logic [Q_BITS-1:0]                     q0;
        logic [Q_BITS-1:0]                     q1;
        logic                                  clamp0;
        logic                                  clamp1;
        logic signed [L_BITS-1:0]              l0;
        logic signed [L_BITS-1:0]              l1;
        logic signed [L_BITS-1:0]              l2;
        logic                                  hit;
        logic [LAM_BITS-1:0]                   la;
        logic [LAM_BITS-1:0]                   lb;
        logic [LAM_BITS-1:0]                   lc;
    } pipe_t;

    typedef struct packed {
        logic [REM_BITS-1:0] r;
        logic [Q_BITS-1:0]   q;
    } div_t;

endpackage

// ===== rtl/barycentric_point_in_triangle_unit.sv =====
// Barycentric point-in-triangle unit: a 27-register pipeline, one word per cycle.
// The quotient pipeline resolves two quotient bits per stage for 35 bits (18 stages).
// Throughput: one word per cycle; the whole pipeline holds while the output stalls.
// Reset clears the valid bits, sets dimension_mode to 3 and tolerance to 1.
`include "barycentric_point_in_triangle_unit_macros.svh"

module barycentric_point_in_triangle_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [bpit_pkg::TOL_BITS-1:0]       cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_x, point_y, point_z, vert_a_x/y/z, vert_b_x/y/z, vert_c_x/y/z
    input  logic [bpit_pkg::IN_BYTES_BITS-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // inside_res, degenerate, lambda_a, lambda_b, lambda_c, zero pad
    output logic [bpit_pkg::OUT_BYTES_BITS-1:0] m_tdata
);
    import bpit_pkg::*;

    logic [1:0]          dim_reg;
    logic [TOL_BITS-1:0] tol_reg;
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  adv;
    pipe_t                 in_word;
    pipe_t                 st_reg  [NUM_STAGES];
    pipe_t                 st_next [NUM_STAGES];

    function automatic div_t div_step(input div_t d, input logic [MAG_BITS-1:0] nm,
                                      input logic [MAG_BITS-1:0] dm, input int k);
        div_t                r;
        logic                nbit;
        logic [REM_BITS-1:0] rr;
        r = d;
        nbit = 1'b0;
        if (k >= Q_FRAC)
        begin
            nbit = nm[6'(k - Q_FRAC)];
        end
        rr = {d.r[REM_BITS-2:0], nbit};
        if (rr >= REM_BITS'(dm))
        begin
            rr = rr - REM_BITS'(dm);
            r.q[6'(k)] = 1'b1;
        end
        r.r = rr;
        return r;
    endfunction

    function automatic logic [LAM_BITS-1:0] lam_sat(input logic signed [L_BITS-1:0] l);
        logic [L_BITS-1:0] m;
        m = l[L_BITS-1] ? L_BITS'(-l) : L_BITS'(l);
        m = m >> LAM_SHIFT;
        if (m > L_BITS'({LAM_BITS{1'b1}}))
        begin
            return {LAM_BITS{1'b1}};
        end
        return m[LAM_BITS-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] crd_at(input pipe_t s, input int k);
        return $signed(s.crd[4'(k)]);
    endfunction

    function automatic pipe_t stage_fn(input int idx, input pipe_t s,
                                       input logic [TOL_BITS-1:0] tol,
                                       input logic [1:0] dim);
        pipe_t                        r;
        int                           i0;
        int                           i1;
        logic signed [DIFF_BITS-1:0]  db;
        logic signed [DIFF_BITS-1:0]  dc;
        logic [DIFF_BITS-1:0]         mb;
        logic [DIFF_BITS-1:0]         mc;
        logic [DIFF_BITS-1:0]         ex;
        logic [DIFF_BITS-1:0]         ey;
        logic [DIFF_BITS-1:0]         ez;
        logic [CMP_BITS-1:0]          rhs;
        logic [CMP_BITS-1:0]          lhs;
        logic [Q_BITS-1:0]            qa;
        logic [Q_BITS-1:0]            qb;
        logic signed [L_BITS-1:0]     ntol;
        div_t                         d0;
        div_t                         d1;
        int                           k;
        r = s;
        i0 = 0;
        i1 = 1;
        if (idx == ST_EXTENT)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                db = DIFF_BITS'(crd_at(s, 6 + ax)) - DIFF_BITS'(crd_at(s, 3 + ax));
                dc = DIFF_BITS'(crd_at(s, 9 + ax)) - DIFF_BITS'(crd_at(s, 3 + ax));
                mb = db[DIFF_BITS-1] ? DIFF_BITS'(-db) : DIFF_BITS'(db);
                mc = dc[DIFF_BITS-1] ? DIFF_BITS'(-dc) : DIFF_BITS'(dc);
                r.ext[ax] = (mb > mc) ? mb : mc;
            end
        end
        if (idx == ST_PLANE)
        begin
            ex = s.ext[0];
            ey = s.ext[1];
            ez = s.ext[2];
            // Project along the axis of smallest extent in 3D mode, else onto XY; ties favour Z, then Y.
            if (dim == DIM_3D)
            begin
                if (ez <= ex && ez <= ey)
                begin
                    i0 = 0;
                    i1 = 1;
                end
                else if (ey <= ex && ey <= ez)
                begin
                    i0 = 0;
                    i1 = 2;
                end
                else
                begin
                    i0 = 1;
                    i1 = 2;
                end
            end
            r.u0 = DIFF_BITS'(crd_at(s, 3 + i0)) - DIFF_BITS'(crd_at(s, 9 + i0));
            r.u1 = DIFF_BITS'(crd_at(s, 3 + i1)) - DIFF_BITS'(crd_at(s, 9 + i1));
            r.v0 = DIFF_BITS'(crd_at(s, 6 + i0)) - DIFF_BITS'(crd_at(s, 9 + i0));
            r.v1 = DIFF_BITS'(crd_at(s, 6 + i1)) - DIFF_BITS'(crd_at(s, 9 + i1));
            r.w0 = DIFF_BITS'(crd_at(s, i0)) - DIFF_BITS'(crd_at(s, 9 + i0));
            r.w1 = DIFF_BITS'(crd_at(s, i1)) - DIFF_BITS'(crd_at(s, 9 + i1));
        end
        if (idx == ST_MUL)
        begin
            r.m_u0v1 = s.u0 * s.v1;
            r.m_u1v0 = s.u1 * s.v0;
            r.m_v1w0 = s.v1 * s.w0;
            r.m_v0w1 = s.v0 * s.w1;
            r.m_u0w1 = s.u0 * s.w1;
            r.m_u1w0 = s.u1 * s.w0;
            r.sq_u0  = s.u0 * s.u0;
            r.sq_u1  = s.u1 * s.u1;
            r.sq_v0  = s.v0 * s.v0;
            r.sq_v1  = s.v1 * s.v1;
            r.t2     = T2_BITS'(tol) * T2_BITS'(tol);
        end
        if (idx == ST_SUM)
        begin
            r.det = DET_BITS'(s.m_u0v1) - DET_BITS'(s.m_u1v0);
            r.n0  = DET_BITS'(s.m_v1w0) - DET_BITS'(s.m_v0w1);
            r.n1  = DET_BITS'(s.m_u0w1) - DET_BITS'(s.m_u1w0);
            r.na  = MAG_BITS'(s.sq_u0) + MAG_BITS'(s.sq_u1);
            r.nb  = MAG_BITS'(s.sq_v0) + MAG_BITS'(s.sq_v1);
        end
        if (idx == ST_ABS)
        begin
            r.dm   = s.det[DET_BITS-1] ? MAG_BITS'(-s.det) : MAG_BITS'(s.det);
            r.nm0  = s.n0[DET_BITS-1] ? MAG_BITS'(-s.n0) : MAG_BITS'(s.n0);
            r.nm1  = s.n1[DET_BITS-1] ? MAG_BITS'(-s.n1) : MAG_BITS'(s.n1);
            r.sgn0 = s.n0[DET_BITS-1] ^ s.det[DET_BITS-1];
            r.sgn1 = s.n1[DET_BITS-1] ^ s.det[DET_BITS-1];
        end
        if (idx == ST_PART)
        begin
            // Operands split into a high part and a 32-bit low part for the squares and products.
            r.dd_hh = (2*HI_BITS)'(s.dm[MAG_BITS-1:32]) * (2*HI_BITS)'(s.dm[MAG_BITS-1:32]);
            r.dd_hl = MAG_BITS'(s.dm[MAG_BITS-1:32]) * MAG_BITS'(s.dm[31:0]);
            r.dd_ll = 64'(s.dm[31:0]) * 64'(s.dm[31:0]);
            r.nn_hh = (2*HI_BITS)'(s.na[MAG_BITS-1:32]) * (2*HI_BITS)'(s.nb[MAG_BITS-1:32]);
            r.nn_hl = MAG_BITS'(s.na[MAG_BITS-1:32]) * MAG_BITS'(s.nb[31:0]);
            r.nn_lh = MAG_BITS'(s.na[31:0]) * MAG_BITS'(s.nb[MAG_BITS-1:32]);
            r.nn_ll = 64'(s.na[31:0]) * 64'(s.nb[31:0]);
            // Quotient below 2^35 exactly when the numerator's top bits stay under det.
            r.r0 = REM_BITS'(s.nm0 >> NUM_SHIFT);
            r.r1 = REM_BITS'(s.nm1 >> NUM_SHIFT);
            r.clamp0 = (s.nm0 >> NUM_SHIFT) >= s.dm;
            r.clamp1 = (s.nm1 >> NUM_SHIFT) >= s.dm;
            r.q0 = '0;
            r.q1 = '0;
        end
        if (idx == ST_SQSUM)
        begin
            r.det2 = (SQ_BITS'(s.dd_hh) << 64) + (SQ_BITS'(s.dd_hl) << 33)
                   + SQ_BITS'(s.dd_ll);
            r.nanb = (SQ_BITS'(s.nn_hh) << 64)
                   + ((SQ_BITS'(s.nn_hl) + SQ_BITS'(s.nn_lh)) << 32) + SQ_BITS'(s.nn_ll);
        end
        if (idx == ST_RPART)
        begin
            for (int c = 0; c < 3; c++)
            begin
                r.plo[c] = 64'(s.t2[31:0]) * 64'(s.nanb[32*c +: 32]);
                r.phi[c] = 64'(s.t2[T2_BITS-1:32]) * 64'(s.nanb[32*c +: 32]);
            end
            r.plo[3] = 64'(s.t2[31:0]) * 64'(s.nanb[SQ_BITS-1:96]);
            r.phi[3] = 64'(s.t2[T2_BITS-1:32]) * 64'(s.nanb[SQ_BITS-1:96]);
        end
        if (idx == ST_RSUM)
        begin
            r.slo = '0;
            r.shi = '0;
            for (int c = 0; c < 4; c++)
            begin
                r.slo = r.slo + (CMP_BITS'(s.plo[c]) << (32 * c));
                r.shi = r.shi + (CMP_BITS'(s.phi[c]) << (32 * c));
            end
        end
        if (idx == ST_DEGEN)
        begin
            rhs = s.slo + (s.shi << 32);
            lhs = CMP_BITS'(s.det2) << 60;
            r.degen = (s.dm == '0) || (lhs < rhs);
        end
        if (idx >= ST_DIV0 && idx < ST_DIV0 + DIV_STAGES)
        begin
            d0 = '{r: s.r0, q: s.q0};
            d1 = '{r: s.r1, q: s.q1};
            for (int t = 0; t < 2; t++)
            begin
                k = Q_BITS - 1 - 2 * (idx - ST_DIV0) - t;
                if (k >= 0)
                begin
                    d0 = div_step(d0, s.nm0, s.dm, k);
                    d1 = div_step(d1, s.nm1, s.dm, k);
                end
            end
            r.r0 = d0.r;
            r.q0 = d0.q;
            r.r1 = d1.r;
            r.q1 = d1.q;
        end
        if (idx == ST_WEIGHT)
        begin
            qa = s.clamp0 ? {Q_BITS{1'b1}} : s.q0;
            qb = s.clamp1 ? {Q_BITS{1'b1}} : s.q1;
            r.l0 = s.sgn0 ? -$signed(L_BITS'(qa)) : $signed(L_BITS'(qa));
            r.l1 = s.sgn1 ? -$signed(L_BITS'(qb)) : $signed(L_BITS'(qb));
            r.l2 = $signed(L_BITS'(1) << Q_FRAC) - r.l0 - r.l1;
            ntol = -$signed(L_BITS'(tol));
            r.hit = !s.degen && (r.l0 >= ntol) && (r.l1 >= ntol) && (r.l2 >= ntol);
        end
        if (idx == ST_OUT)
        begin
            r.la = s.hit ? lam_sat(s.l0) : '0;
            r.lb = s.hit ? lam_sat(s.l1) : '0;
            r.lc = s.hit ? lam_sat(s.l2) : '0;
        end
        return r;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_3D;
            tol_reg <= TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_DIM: dim_reg <= cfg_wdata[1:0];
                REG_TOL: tol_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves when the output stage is empty or drained.
    assign adv      = !vld_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        in_word     = '0;
        in_word.crd = s_tdata[IN_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        if (g == 0)
        begin : g_first
            assign st_next[g] = stage_fn(g, in_word, tol_reg, dim_reg);
        end
        else
        begin : g_rest
            assign st_next[g] = stage_fn(g, st_reg[g-1], tol_reg, dim_reg);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {(OUT_BYTES_BITS - OUT_BITS)'(0),
                       st_reg[NUM_STAGES-1].lc, st_reg[NUM_STAGES-1].lb,
                       st_reg[NUM_STAGES-1].la, st_reg[NUM_STAGES-1].degen,
                       st_reg[NUM_STAGES-1].hit};

    `BPIT_ASSERT_IMPL(a_inside_not_degen, m_tvalid, !(m_tdata[0] && m_tdata[1]), "inside and degenerate both set")
    `BPIT_ASSERT_IMPL(a_zero_weights, m_tvalid && !m_tdata[0], m_tdata[OUT_BITS-1:2] == '0, "weights nonzero for an outside point")
    `BPIT_ASSERT_IMPL(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `BPIT_ASSERT_NEXT(a_dim_write, cfg_wr_en && cfg_addr == REG_DIM, dim_reg == $past(cfg_wdata[1:0]), "dimension_mode write lost")

endmodule

// ===== tb/tb_barycentric_point_in_triangle_unit.sv =====
// Self-checking testbench for the barycentric point-in-triangle unit.
// Predicts every result word with its own fixed-point model; needs bpit_pkg and the RTL.
`timescale 1ns / 1ps

class bary_scoreboard;
    typedef struct {
        logic        hit;
        logic        degen;
        logic [30:0] la;
        logic [30:0] lb;
        logic [30:0] lc;
    } bary_res_t;

    bary_res_t   pending[$];
    logic [1:0]  dim_mode;
    logic [30:0] tol;
    int          errors;
    int          n_inside;
    int          n_degen;
    int          n_checked;

    function new();
        dim_mode = bpit_pkg::DIM_3D;
        tol = bpit_pkg::TOL_RESET;
        errors = 0;
        n_inside = 0;
        n_degen = 0;
        n_checked = 0;
    endfunction

    // Quotient num * 2^30 / den, truncated toward zero, magnitude clamped to 35 bits.
    function longint weight_q30(longint num, longint den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        n = 128'(num < 0 ? -num : num) << 30;
        d = 128'(den < 0 ? -den : den);
        if (n >= (d << 35))
            q = (128'd1 << 35) - 1;
        else
            q = n / d;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function logic [30:0] weight_out(longint l);
        longint m;
        m = (l < 0 ? -l : l) >>> (30 - bpit_pkg::LAMBDA_FRAC_BITS);
        return (m > 64'h7FFFFFFF) ? 31'h7FFFFFFF : m[30:0];
    endfunction

    function void note_input(logic [bpit_pkg::IN_BYTES_BITS-1:0] d);
        longint      crd[12];
        longint      ex, ey, ez, ux, uy, vx, vy, wx, wy, det, dm, na, nb, l0, l1, l2;
        logic [255:0] lhs, rhs;
        int          i0, i1;
        bary_res_t   r;
        for (int k = 0; k < 12; k++)
            crd[k] = longint'($signed(d[k*24 +: 24]));
        // Layout: point 0..2, vertex a 3..5, b 6..8, c 9..11.
        i0 = 0;
        i1 = 1;
        if (dim_mode == bpit_pkg::DIM_3D)
        begin
            ex = max_abs(crd[6] - crd[3], crd[9] - crd[3]);
            ey = max_abs(crd[7] - crd[4], crd[10] - crd[4]);
            ez = max_abs(crd[8] - crd[5], crd[11] - crd[5]);
            if (ez <= ex && ez <= ey)
            begin
                i0 = 0; i1 = 1;
            end
            else if (ey <= ex && ey <= ez)
            begin
                i0 = 0; i1 = 2;
            end
            else
            begin
                i0 = 1; i1 = 2;
            end
        end
        ux = crd[3 + i0] - crd[9 + i0];
        uy = crd[3 + i1] - crd[9 + i1];
        vx = crd[6 + i0] - crd[9 + i0];
        vy = crd[6 + i1] - crd[9 + i1];
        wx = crd[i0] - crd[9 + i0];
        wy = crd[i1] - crd[9 + i1];
        det = ux * vy - uy * vx;
        dm = det < 0 ? -det : det;
        na = ux * ux + uy * uy;
        nb = vx * vx + vy * vy;
        lhs = (256'(dm) * 256'(dm)) << 60;
        rhs = 256'(tol) * 256'(tol) * 256'(na) * 256'(nb);
        r.degen = (det == 0) || (lhs < rhs);
        r.hit = 1'b0;
        r.la = '0;
        r.lb = '0;
        r.lc = '0;
        if (!r.degen)
        begin
            l0 = weight_q30(vy * wx - vx * wy, det);
            l1 = weight_q30(ux * wy - uy * wx, det);
            l2 = (64'sd1 <<< 30) - l0 - l1;
            r.hit = (l0 >= -longint'(tol)) && (l1 >= -longint'(tol))
                    && (l2 >= -longint'(tol));
            if (r.hit)
            begin
                r.la = weight_out(l0);
                r.lb = weight_out(l1);
                r.lc = weight_out(l2);
            end
        end
        pending.insert(pending.size(), r);
    endfunction

    function longint max_abs(longint a, longint b);
        longint x, y;
        x = a < 0 ? -a : a;
        y = b < 0 ? -b : b;
        return x > y ? x : y;
    endfunction

    function void check_result(logic [bpit_pkg::OUT_BYTES_BITS-1:0] d);
        bary_res_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result word %h", $time, d);
            errors++;
            return;
        end
        e = pending.pop_front();
        n_checked++;
        if (e.hit) n_inside++;
        if (e.degen) n_degen++;
        if (d[0] !== e.hit)
        begin
            $display("%0t: inside_res expected %0d got %0d", $time, e.hit, d[0]);
            errors++;
        end
        if (d[1] !== e.degen)
        begin
            $display("%0t: degenerate expected %0d got %0d", $time, e.degen, d[1]);
            errors++;
        end
        if (d[32:2] !== e.la)
        begin
            $display("%0t: lambda_a expected %h got %h", $time, e.la, d[32:2]);
            errors++;
        end
        if (d[63:33] !== e.lb)
        begin
            $display("%0t: lambda_b expected %h got %h", $time, e.lb, d[63:33]);
            errors++;
        end
        if (d[94:64] !== e.lc)
        begin
            $display("%0t: lambda_c expected %h got %h", $time, e.lc, d[94:64]);
            errors++;
        end
    endfunction
endclass

module tb_barycentric_point_in_triangle_unit;
    import bpit_pkg::*;

    localparam int DRAIN_CYCLES = 40;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic                      cfg_addr;
    logic [TOL_BITS-1:0]       cfg_wdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_BYTES_BITS-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_BYTES_BITS-1:0] m_tdata;

    bary_scoreboard tri_sb;
    int             snd_idle_pct;
    int             rcv_idle_pct;
    int             n_sent;

    barycentric_point_in_triangle_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("** barycentric_point_in_triangle_unit: FAILED **");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready = ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tri_sb.check_result(m_tdata);
    end

    function automatic logic [23:0] clip24(longint v);
        if (v > 8388607) return 24'h7FFFFF;
        if (v < -8388608) return 24'h800000;
        return v[23:0];
    endfunction

    function automatic logic [IN_BYTES_BITS-1:0] pack_tri(longint c[12]);
        logic [IN_BYTES_BITS-1:0] d;
        d = '0;
        for (int k = 0; k < 12; k++)
            d[k*24 +: 24] = clip24(c[k]);
        return d;
    endfunction

    task automatic send_word(logic [IN_BYTES_BITS-1:0] d);
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = d;
        do
            @(posedge clk);
        while (!s_tready);
        tri_sb.note_input(d);
        n_sent++;
        // Valid is left high here; the next send_word sends its word or drops it while idle, and quiesce drops it.
        fork
            begin
                @(negedge clk);
            end
        join_none
    endtask

    task automatic quiesce();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (tri_sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic addr, logic [TOL_BITS-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (addr == REG_DIM)
            tri_sb.dim_mode = val[1:0];
        else
            tri_sb.tol = val;
    endtask

    task automatic send_directed();
        longint c[12];
        longint v;
        // Degenerate: all corners coincide, and a collinear triangle.
        c = '{0, 0, 0, 100, 100, 100, 100, 100, 100, 100, 100, 100};
        send_word(pack_tri(c));
        c = '{5, 5, 0, 0, 0, 0, 1000, 1000, 0, 2000, 2000, 0};
        send_word(pack_tri(c));
        // Unit triangle in XY with the point at two corners, the centroid and two points outside.
        for (int k = 0; k < 5; k++)
        begin
            c = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 0};
            case (k)
                0: begin c[0] = 65536; c[1] = 0; end
                1: begin c[0] = 0; c[1] = 65536; end
                2: begin c[0] = 21845; c[1] = 21845; end
                3: begin c[0] = 65536; c[1] = 65536; end
                default: begin c[0] = -1; c[1] = 0; end
            endcase
            send_word(pack_tri(c));
        end
        // Triangles flat in each axis so every projection plane is chosen in 3D mode.
        c = '{10, 10, 20, 0, 0, 0, 4000, 0, 9000, 0, 3000, 50};
        send_word(pack_tri(c));
        c = '{10, 20, 10, 0, 0, 0, 0, 4000, 9000, 3000, 0, 50};
        send_word(pack_tri(c));
        c = '{20, 10, 10, 0, 0, 0, 9000, 4000, 0, 50, 0, 3000};
        send_word(pack_tri(c));
        // Coordinate extremes: largest triangle and point at the opposite corner.
        c = '{8388607, 8388607, -8388608, -8388608, -8388608, 8388607,
              8388607, -8388608, -8388608, -8388608, 8388607, 0};
        send_word(pack_tri(c));
        c = '{-8388608, -8388608, 8388607, 8388607, 8388607, -8388608,
              -8388608, 8388607, 8388607, 8388607, -8388608, -1};
        send_word(pack_tri(c));
        // Tiny sliver triangle, and a huge triangle containing the origin.
        c = '{1, 0, 0, 0, 0, 0, 8388607, 1, 0, -8388608, 0, 0};
        send_word(pack_tri(c));
        v = 8388607;
        c = '{0, 0, 0, -v, -v, 0, v, -v, 0, 0, v, 0};
        send_word(pack_tri(c));
    endtask

    task automatic send_random(int count);
        longint c[12];
        longint span, ctr, wa, wb;
        int     shape;
        for (int n = 0; n < count; n++)
        begin
            shape = $urandom_range(0, 9);
            if (shape < 2)
            begin
                for (int k = 0; k < 12; k++)
                    c[k] = longint'($signed(24'($urandom)));
            end
            else
            begin
                span = longint'(1) << $urandom_range(2, 22);
                for (int k = 3; k < 12; k++)
                begin
                    ctr = longint'($signed(24'($urandom))) >>> $urandom_range(1, 8);
                    c[k] = ctr / 4 + longint'($urandom_range(0, 2 * span)) - span;
                end
                if (shape == 2)
                begin
                    ctr = longint'($signed(24'($urandom)));
                    for (int k = 3; k < 12; k += 3)
                        c[k + $urandom_range(0, 2) - (k % 3)] = ctr;
                end
                // Point as a weighted mix of the corners, mostly inside.
                wa = $urandom_range(0, 300);
                wb = $urandom_range(0, 300 - (wa > 280 ? 0 : wa / 2));
                for (int k = 0; k < 3; k++)
                    c[k] = c[9 + k] + ((c[3 + k] - c[9 + k]) * wa
                           + (c[6 + k] - c[9 + k]) * wb) / 256
                           + longint'($urandom_range(0, 4)) - 2;
                if (shape == 9)
                    c[$urandom_range(0, 2)] = longint'($signed(24'($urandom)));
            end
            send_word(pack_tri(c));
        end
    endtask

    initial
    begin
        logic [1:0]          dims[6];
        logic [TOL_BITS-1:0] tols[6];
        dims = '{2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3};
        tols = '{31'd0, 31'd1, 31'h7FFFFFFF, 31'd1073741824, 31'd1048576, 31'd1};
        tri_sb = new();
        n_sent = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_DIM;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        snd_idle_pct = 32;
        rcv_idle_pct = 72;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Reset values first.
        send_directed();
        for (int ph = 0; ph < 6; ph++)
        begin
            quiesce();
            snd_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 72 : 0;
            rcv_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 32 : 0;
            write_reg(REG_DIM, TOL_BITS'(dims[ph]));
            write_reg(REG_TOL, tols[ph]);
            send_directed();
            send_random(260);
        end
        quiesce();
        $display("Sent %0d words over six register settings; %0d results, %0d inside, %0d degenerate.",
                 n_sent, tri_sb.n_checked, tri_sb.n_inside, tri_sb.n_degen);
        if (tri_sb.errors == 0 && tri_sb.pending.size() == 0)
            $display("** barycentric_point_in_triangle_unit: PASSED **");
        else
            $display("** barycentric_point_in_triangle_unit: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/bpit_pkg.sv
rtl/barycentric_point_in_triangle_unit.sv
tb/tb_barycentric_point_in_triangle_unit.sv
